>>> sv/gs1d_pkg.sv
package gs1d_pkg;

  // Register map
  localparam int unsigned NUM_WEIGHTS = 7;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned WEIGHT_W    = 17;
  localparam int unsigned RADIUS_W    = 3;
  localparam int unsigned WSEL_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CENTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SIX    = 3'd7;

  localparam logic [WEIGHT_W-1:0] WEIGHT_UNITY = 17'h10000;

  // Q1.16 rounding
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned ROUND_HALF = 32768;

  typedef logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0] weight_arr_t;

  // Controller to datapath
  typedef struct packed {
    logic fill;        // first word of a vector: fill the whole window
    logic push;        // shift in the accepted word
    logic flush_push;  // replicate the newest sample past the end
    logic mac_start;   // clear accumulator, snapshot window
    logic mac_step;    // one tap pair per cycle
    logic emit;        // load the output register
    logic final_flag;  // word carries the end-of-vector mark
  } gs1d_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take a word this cycle
    logic k_last;      // current tap is the outermost one
  } gs1d_sts_t;

endpackage

>>> sv/gs1d_regs.sv
module gs1d_regs
  import gs1d_pkg::*;
#(
  parameter int unsigned MAX_RADIUS = 6,
  parameter int unsigned CNT_W      = $clog2(MAX_RADIUS + 2)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WEIGHT_W-1:0]  cfg_data_i,
  output logic [CNT_W-1:0]     radius_o,
  output weight_arr_t          weights_o
);

  logic [RADIUS_W-1:0] radius_q;
  weight_arr_t         weights_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= '0;
      // center weight at unity, all other taps zero
      weights_q <= weight_arr_t'(WEIGHT_UNITY);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_RADIUS) begin
        radius_q <= cfg_data_i[RADIUS_W-1:0];
      end else begin
        // every other index selects one of the seven weights
        weights_q[WSEL_W'(cfg_index_i - REG_WEIGHT_CENTER)] <= cfg_data_i;
      end
    end
  end

  // Clamp oversize radius to the built window
  always_comb begin
    if (32'(radius_q) > MAX_RADIUS) begin
      radius_o = CNT_W'(MAX_RADIUS);
    end else begin
      radius_o = CNT_W'(radius_q);
    end
  end

  assign weights_o = weights_q;

endmodule

>>> sv/gs1d_ctrl.sv
module gs1d_ctrl
  import gs1d_pkg::*;
#(
  parameter int unsigned MAX_RADIUS = 6,
  parameter int unsigned CNT_W      = $clog2(MAX_RADIUS + 2)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             vector_end_i,
  output logic             in_ready_o,
  input  logic [CNT_W-1:0] radius_i,
  input  gs1d_sts_t        sts_i,
  output gs1d_cmd_t        cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_MAC   = 5'b00100,
    S_EMIT  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_e;

  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_RADIUS + 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] seen_q, seen_d;
  logic [CNT_W-1:0] flush_q, flush_d;
  logic             start_q, start_d;
  logic             last_q, last_d;
  logic [CNT_W-1:0] seen_inc;

  assign seen_inc = (seen_q == COUNT_MAX) ? seen_q : seen_q + CNT_W'(1);

  always_comb begin
    state_d = state_q;
    seen_d  = seen_q;
    flush_d = flush_q;
    start_d = start_q;
    last_d  = last_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    cmd_o.final_flag = last_q && (flush_q == '0);

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.fill = start_q;
          cmd_o.push = !start_q;
          seen_d  = start_q ? CNT_W'(1) : seen_inc;
          start_d = 1'b0;
          last_d  = vector_end_i;
          flush_d = radius_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (seen_q > radius_i) begin
          if (radius_i == '0) begin
            state_d = S_EMIT;
          end else begin
            cmd_o.mac_start = 1'b1;
            state_d = S_MAC;
          end
        end else if (last_q && (flush_q != '0)) begin
          state_d = S_FLUSH;
        end else begin
          if (last_q) begin
            start_d = 1'b1;
            seen_d  = '0;
          end
          state_d = S_IDLE;
        end
      end
      S_MAC: begin
        cmd_o.mac_step = 1'b1;
        if (sts_i.k_last) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (last_q && (flush_q != '0)) begin
            state_d = S_FLUSH;
          end else begin
            if (last_q) begin
              start_d = 1'b1;
              seen_d  = '0;
            end
            state_d = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        cmd_o.flush_push = 1'b1;
        flush_d = flush_q - CNT_W'(1);
        seen_d  = seen_inc;
        state_d = S_CHECK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      seen_q  <= '0;
      flush_q <= '0;
      start_q <= 1'b1;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
      flush_q <= flush_d;
      start_q <= start_d;
      last_q  <= last_d;
    end
  end

endmodule

>>> sv/gs1d_dp.sv
module gs1d_dp
  import gs1d_pkg::*;
#(
  parameter int unsigned MAX_RADIUS  = 6,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned CNT_W       = $clog2(MAX_RADIUS + 2)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic [CNT_W-1:0]              radius_i,
  input  weight_arr_t                   weights_i,
  input  gs1d_cmd_t                     cmd_i,
  output gs1d_sts_t                     sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          final_out_o
);

  localparam int unsigned WIN    = 2 * MAX_RADIUS + 1;
  localparam int unsigned IDX_W  = $clog2(2 * MAX_RADIUS + 2);
  localparam int unsigned PAIR_W = SAMPLE_BITS + 1;
  localparam int unsigned PROD_W = PAIR_W + WEIGHT_W + 1;
  localparam int unsigned ACC_W  = SAMPLE_BITS + 22;

  localparam logic signed [ACC_W-1:0] SAT_MAX =
    ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  logic signed [SAMPLE_BITS-1:0] window_q [WIN];
  logic signed [SAMPLE_BITS-1:0] lo_q     [WIN];
  logic signed [ACC_W-1:0]       acc_q;
  logic [CNT_W-1:0]              k_q;
  logic signed [SAMPLE_BITS-1:0] out_data_q;
  logic                          out_final_q;
  logic                          out_valid_q;

  logic [IDX_W-1:0]              ctr_idx;
  logic [IDX_W-1:0]              hi_idx;
  logic signed [SAMPLE_BITS-1:0] lo_rd;
  logic signed [SAMPLE_BITS-1:0] hi_rd;
  logic signed [PAIR_W-1:0]      pair;
  logic [WEIGHT_W-1:0]           w_sel;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       rnd;
  logic signed [ACC_W-1:0]       quo;
  logic signed [SAMPLE_BITS-1:0] sat_val;

  // Lower tap walks down the snapshot by shifting it, upper tap reads the window
  assign ctr_idx = IDX_W'(radius_i);
  assign hi_idx  = ctr_idx + IDX_W'(k_q);
  assign lo_rd   = lo_q[ctr_idx];
  assign hi_rd   = window_q[hi_idx];
  assign w_sel   = weights_i[WSEL_W'(k_q)];

  always_comb begin
    if (k_q == '0) begin
      pair = PAIR_W'(lo_rd);
    end else begin
      pair = PAIR_W'(lo_rd) + PAIR_W'(hi_rd);
    end
  end

  assign prod = $signed({1'b0, w_sel}) * pair;

  // Round half up, then clamp
  assign rnd = acc_q + ACC_W'(ROUND_HALF);
  assign quo = rnd >>> FRAC_BITS;

  always_comb begin
    if (quo > SAT_MAX) begin
      sat_val = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (quo < SAT_MIN) begin
      sat_val = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      sat_val = quo[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill) begin
      for (int i = 0; i < WIN; i++) begin
        window_q[i] <= sample_in_i;
      end
    end else if (cmd_i.push || cmd_i.flush_push) begin
      for (int i = 1; i < WIN; i++) begin
        window_q[i] <= window_q[i-1];
      end
      if (cmd_i.push) begin
        window_q[0] <= sample_in_i;
      end
    end

    if (cmd_i.mac_start) begin
      lo_q  <= window_q;
      acc_q <= '0;
      k_q   <= '0;
    end else if (cmd_i.mac_step) begin
      for (int i = 1; i < WIN; i++) begin
        lo_q[i] <= lo_q[i-1];
      end
      acc_q <= acc_q + ACC_W'(prod);
      k_q   <= k_q + CNT_W'(1);
    end

    if (cmd_i.emit) begin
      out_data_q  <= (radius_i == '0) ? window_q[0] : sat_val;
      out_final_q <= cmd_i.final_flag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.k_last   = (k_q == radius_i);

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;
  assign final_out_o  = out_final_q;

endmodule

>>> sv/gaussian_smooth_1d_edge_replicate.sv
// Channel   Handshake              Payload
// --------  ---------------------  ------------------------------------------
// in        in_valid_i/in_ready_o  sample_in_i (signed), vector_end_i
// out       out_valid_o/out_ready_i sample_out_o (signed), final_out_o
// cfg       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i (radius, 7 weights)
//
// Work: each output word at radius r > 0 comes from a single multiply-accumulate
// that walks the center tap and the r tap pairs one per cycle; at radius 0 the
// newest sample is emitted without it.
// A word flagged vector_end adds r replicated-sample steps.
// Reset: radius 0, center weight 1.0, other weights 0; next word opens a vector.
// Stalls: a full output register holds the emit step; the next input word is
// taken as soon as the previous one is done, even while a result waits.
module gaussian_smooth_1d_edge_replicate
  import gs1d_pkg::*;
#(
  parameter int unsigned MAX_RADIUS  = 6,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic                          vector_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          final_out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [WEIGHT_W-1:0]           cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(MAX_RADIUS + 2);

  logic [CNT_W-1:0] radius_eff;
  weight_arr_t      weights;
  gs1d_cmd_t        cmd;
  gs1d_sts_t        sts;

  // Config writes are always taken; the user must send them only while the block is idle (not enforced here)
  assign cfg_ready_o = 1'b1;

  gs1d_regs #(
    .MAX_RADIUS (MAX_RADIUS),
    .CNT_W      (CNT_W)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .radius_o    (radius_eff),
    .weights_o   (weights)
  );

  // Sequencer: window update, tap walk, emit, end-of-vector replication
  gs1d_ctrl #(
    .MAX_RADIUS (MAX_RADIUS),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .vector_end_i (vector_end_i),
    .in_ready_o   (in_ready_o),
    .radius_i     (radius_eff),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // Window, shared MAC, round/saturate and output register
  gs1d_dp #(
    .MAX_RADIUS  (MAX_RADIUS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_in_i  (sample_in_i),
    .radius_i     (radius_eff),
    .weights_i    (weights),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .final_out_o  (final_out_o)
  );

  // One word in flight: ready drops right after a word is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while previous word still in work");

  // Never overwrite a result that has not been taken
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || out_ready_i))
    else $error("emit into occupied output register");

  // Tap walk only runs for a real kernel
  a_mac_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mac_step |-> (radius_eff != '0))
    else $error("tap walk at radius zero");

  // A final word leaves the block waiting for a new vector
  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && cmd.final_flag) |=> in_ready_o)
    else $error("block not idle after final word");

endmodule
